@@ design/sgps_pkg.sv @@
`default_nettype none
package sgps_pkg;

  localparam int MAX_ATOMS_DEF  = 256;
  localparam int COORD_BITS_DEF = 20;

  localparam int OP_W       = 2;
  localparam int RADIUS_W   = 15;
  localparam int PAD_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_SHIFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_SHIFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_CUTOFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_CUTOFF  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FIXED_PADDING = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING       = 3'd6;

  localparam logic [14:0] SPACING_RESET = 15'd1024;

  // walk position width: the wider of coordinate and padding plus two bits of headroom
  function automatic int pos_width(int coord_bits);
    return ((coord_bits > PAD_W + 1) ? coord_bits : PAD_W + 1) + 2;
  endfunction

  typedef struct packed {
    logic [2:0]         mode;
    logic [14:0]        outer_shift;
    logic signed [15:0] inner_shift;
    logic [14:0]        outer_cutoff;
    logic [14:0]        inner_cutoff;
    logic [14:0]        fixed_padding;
    logic [14:0]        spacing;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic back_busy;
  } flow_t;

endpackage
`default_nettype wire

@@ design/sgps_queue.sv @@
`default_nettype none
module sgps_queue #(
  parameter int DW = 61
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  input  logic          pop_i,
  output logic [DW-1:0] pop_data_o,
  output logic          full_o,
  output logic          empty_o
);

  // two-entry fifo
  logic [DW-1:0] buf_q [2];
  logic          wr_q, wr_d, rd_q, rd_d;
  logic [1:0]    cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= push_data_i;
    end
  end

  assign pop_data_o = buf_q[rd_q];
  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);

endmodule
`default_nettype wire

@@ design/sgps_front.sv @@
`default_nettype none
module sgps_front
  import sgps_pkg::*;
#(
  parameter int MAX_ATOMS  = MAX_ATOMS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CW = $clog2(MAX_ATOMS + 1),
  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
  localparam int EW = 3 * COORD_BITS + RADIUS_W,
  localparam int WB = pos_width(COORD_BITS),
  localparam int JW = 3 * WB + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  flow_t                        flow_i,
  input  logic                         in_valid_i,
  input  logic [OP_W-1:0]              op_i,
  input  logic signed [COORD_BITS-1:0] atom_x_i,
  input  logic signed [COORD_BITS-1:0] atom_y_i,
  input  logic signed [COORD_BITS-1:0] atom_z_i,
  input  logic [RADIUS_W-1:0]          atom_radius_i,
  output logic                         in_stall_o,
  output logic                         push_o,
  output logic [JW-1:0]                push_data_o,
  output logic                         mem_we_o,
  output logic [AW-1:0]                mem_addr_o,
  output logic [EW-1:0]                mem_data_o,
  output logic [CW-1:0]                count_o
);

  logic [CW-1:0]                count_q, count_d;
  logic signed [COORD_BITS-1:0] bmin_q [3];
  logic signed [COORD_BITS-1:0] bmin_d [3];
  logic signed [COORD_BITS-1:0] bmax_q [3];
  logic signed [COORD_BITS-1:0] bmax_d [3];
  logic [PAD_W-1:0]             rpad_q, rpad_d;
  logic signed [WB-1:0]         pos_q [3];
  logic signed [WB-1:0]         pos_d [3];
  logic                         started_q, started_d;
  logic                         done_q, done_d;

  logic                         accept;
  logic                         tbl_op;
  logic [PAD_W-1:0]             pad;
  logic signed [WB-1:0]         pad_w, step_w;
  logic signed [WB-1:0]         lo [3];
  logic signed [WB-1:0]         hi [3];
  logic signed [WB-1:0]         cur [3];
  logic signed [WB-1:0]         nxt [3];
  logic signed [COORD_BITS-1:0] ain [3];
  logic                         box_empty, last;
  logic [PAD_W-1:0]             r_pad;

  assign tbl_op     = (op_i == OP_LOAD) || (op_i == OP_CLEAR);
  assign in_stall_o = flow_i.full || (tbl_op && (flow_i.back_busy || !flow_i.empty));
  assign accept     = in_valid_i && !in_stall_o;

  assign ain[0] = atom_x_i;
  assign ain[1] = atom_y_i;
  assign ain[2] = atom_z_i;

  always_comb begin
    pad    = cfg_i.mode[0] ? rpad_q : {1'b0, cfg_i.fixed_padding};
    pad_w  = $signed({{(WB - PAD_W){1'b0}}, pad});
    step_w = (cfg_i.spacing == 15'd0) ? WB'(1) : $signed({{(WB - 15){1'b0}}, cfg_i.spacing});
    for (int a = 0; a < 3; a++) begin
      lo[a]  = $signed({{(WB - COORD_BITS){bmin_q[a][COORD_BITS-1]}}, bmin_q[a]}) - pad_w;
      hi[a]  = $signed({{(WB - COORD_BITS){bmax_q[a][COORD_BITS-1]}}, bmax_q[a]}) + pad_w;
      cur[a] = started_q ? pos_q[a] : lo[a];
    end
    box_empty = (cur[0] >= hi[0]) || (cur[1] >= hi[1]) || (cur[2] >= hi[2]);

    // z fastest, then y, then x
    nxt[0] = cur[0];
    nxt[1] = cur[1];
    nxt[2] = cur[2] + step_w;
    last   = 1'b0;
    if (nxt[2] >= hi[2]) begin
      nxt[2] = lo[2];
      nxt[1] = cur[1] + step_w;
      if (nxt[1] >= hi[1]) begin
        nxt[1] = lo[1];
        nxt[0] = cur[0] + step_w;
        last   = (nxt[0] >= hi[0]);
      end
    end
  end

  assign r_pad = {1'b0, atom_radius_i} + {1'b0, cfg_i.outer_shift};

  always_comb begin
    count_d   = count_q;
    rpad_d    = rpad_q;
    started_d = started_q;
    done_d    = done_q;
    for (int a = 0; a < 3; a++) begin
      bmin_d[a] = bmin_q[a];
      bmax_d[a] = bmax_q[a];
      pos_d[a]  = pos_q[a];
    end
    mem_we_o = 1'b0;
    push_o   = 1'b0;
    if (accept) begin
      case (op_i)
        OP_LOAD: begin
          if (count_q < CW'(MAX_ATOMS)) begin
            mem_we_o = 1'b1;
            count_d  = count_q + CW'(1);
            for (int a = 0; a < 3; a++) begin
              if (ain[a] < bmin_q[a]) bmin_d[a] = ain[a];
              if (ain[a] > bmax_q[a]) bmax_d[a] = ain[a];
            end
            if (r_pad > rpad_q) rpad_d = r_pad;
          end
        end
        OP_STEP: begin
          if ((count_q != '0) && !done_q) begin
            started_d = 1'b1;
            if (box_empty) begin
              done_d = 1'b1;
              for (int a = 0; a < 3; a++) pos_d[a] = cur[a];
            end else begin
              push_o = 1'b1;
              done_d = last;
              for (int a = 0; a < 3; a++) pos_d[a] = nxt[a];
            end
          end
        end
        OP_CLEAR: begin
          count_d   = '0;
          rpad_d    = '0;
          started_d = 1'b0;
          done_d    = 1'b0;
          for (int a = 0; a < 3; a++) begin
            bmin_d[a] = {1'b0, {(COORD_BITS - 1){1'b1}}};
            bmax_d[a] = {1'b1, {(COORD_BITS - 1){1'b0}}};
            pos_d[a]  = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rpad_q    <= '0;
      started_q <= 1'b0;
      done_q    <= 1'b0;
      for (int a = 0; a < 3; a++) begin
        bmin_q[a] <= {1'b0, {(COORD_BITS - 1){1'b1}}};
        bmax_q[a] <= {1'b1, {(COORD_BITS - 1){1'b0}}};
        pos_q[a]  <= '0;
      end
    end else begin
      count_q   <= count_d;
      rpad_q    <= rpad_d;
      started_q <= started_d;
      done_q    <= done_d;
      for (int a = 0; a < 3; a++) begin
        bmin_q[a] <= bmin_d[a];
        bmax_q[a] <= bmax_d[a];
        pos_q[a]  <= pos_d[a];
      end
    end
  end

  // full-width position, the distance test needs the unwrapped point
  assign push_data_o = {cur[0], cur[1], cur[2], last};
  assign mem_addr_o  = count_q[AW-1:0];
  assign mem_data_o  = {atom_x_i, atom_y_i, atom_z_i, atom_radius_i};
  assign count_o     = count_q;

endmodule
`default_nettype wire

@@ design/sgps_back.sv @@
`default_nettype none
module sgps_back
  import sgps_pkg::*;
#(
  parameter int MAX_ATOMS  = MAX_ATOMS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int CW = $clog2(MAX_ATOMS + 1),
  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1,
  localparam int EW = 3 * COORD_BITS + RADIUS_W,
  localparam int PW = pos_width(COORD_BITS),
  localparam int JW = 3 * PW + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cfg_t                         cfg_i,
  input  logic                         mem_we_i,
  input  logic [AW-1:0]                mem_addr_i,
  input  logic [EW-1:0]                mem_data_i,
  input  logic [CW-1:0]                count_i,
  input  logic                         q_empty_i,
  input  logic [JW-1:0]                q_data_i,
  output logic                         pop_o,
  output logic                         busy_o,
  output logic                         out_load_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] point_x_o,
  output logic signed [COORD_BITS-1:0] point_y_o,
  output logic signed [COORD_BITS-1:0] point_z_o,
  output logic                         in_shell_o,
  output logic                         keep_o,
  output logic                         last_point_o
);

  localparam int C  = COORD_BITS;
  localparam int SQ = 2 * (PW + 1);
  localparam int SW = (SQ + 2 > 36) ? SQ + 2 : 36;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [EW-1:0]        mem [MAX_ATOMS];
  logic [EW-1:0]        rd_q;

  logic [1:0]           st_q, st_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic signed [PW-1:0] p_q [3];
  logic                 last_q;
  logic                 v1_q, v2_q, v3_q;
  logic signed [PW:0]   dd_q [3];
  logic [PAD_W-1:0]     ro_q;
  logic signed [17:0]   ri_q;
  logic [SQ-1:0]        sq_q [3];
  logic [31:0]          ro2_q;
  logic [35:0]          ri2_q;
  logic                 hit_in_q, hit_out_q;

  logic signed [C-1:0]  e [3];
  logic [RADIUS_W-1:0]  er;
  logic signed [SQ-1:0] prod [3];
  logic signed [35:0]   ri_prod;
  logic [SW-1:0]        d2;
  logic                 issue, out_free;

  logic                 ov_q;
  logic signed [C-1:0]  op_q [3];
  logic                 oin_q, okeep_q, olast_q;

  always_ff @(posedge clk_i) begin
    if (mem_we_i) begin
      mem[mem_addr_i] <= mem_data_i;
    end
    rd_q <= mem[cnt_q[AW-1:0]];
  end

  assign issue    = (st_q == ST_RUN);
  assign pop_o    = (st_q == ST_IDLE) && !q_empty_i;
  assign busy_o   = (st_q != ST_IDLE);
  assign out_free = !ov_q || !out_stall_i;
  assign out_load_o = (st_q == ST_DONE) && out_free;

  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    case (st_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (!q_empty_i) st_d = ST_RUN;
      end
      ST_RUN: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == count_i - CW'(1)) st_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q) st_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) st_d = ST_IDLE;
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign e[0] = rd_q[EW-1 -: C];
  assign e[1] = rd_q[EW-1-C -: C];
  assign e[2] = rd_q[EW-1-2*C -: C];
  assign er   = rd_q[RADIUS_W-1:0];

  always_comb begin
    for (int a = 0; a < 3; a++) prod[a] = dd_q[a] * dd_q[a];
    ri_prod = ri_q * ri_q;
    d2 = SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
  end

  // three-stage distance pipe: read, difference, square, then compare
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      dd_q[a] <= {p_q[a][PW-1], p_q[a]} - {{(PW + 1 - C){e[a][C-1]}}, e[a]};
      sq_q[a] <= prod[a][SQ-1:0];
    end
    ro_q  <= cfg_i.mode[0] ? ({1'b0, er} + {1'b0, cfg_i.outer_shift})
                           : {1'b0, cfg_i.outer_cutoff};
    ri_q  <= cfg_i.mode[1] ? ($signed({3'b000, er})
                              + $signed({{2{cfg_i.inner_shift[15]}}, cfg_i.inner_shift}))
                           : $signed({3'b000, cfg_i.inner_cutoff});
    ro2_q <= ro_q * ro_q;
    ri2_q <= ri_prod[35:0];
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      p_q[0] <= q_data_i[JW-1 -: PW];
      p_q[1] <= q_data_i[JW-1-PW -: PW];
      p_q[2] <= q_data_i[JW-1-2*PW -: PW];
      last_q <= q_data_i[0];
    end
    if (out_load_o) begin
      for (int a = 0; a < 3; a++) op_q[a] <= p_q[a][C-1:0];
      oin_q   <= hit_out_q && !hit_in_q;
      okeep_q <= (hit_out_q && !hit_in_q) || cfg_i.mode[2];
      olast_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      cnt_q     <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      hit_in_q  <= 1'b0;
      hit_out_q <= 1'b0;
      ov_q      <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      v1_q <= issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (pop_o) begin
        hit_in_q  <= 1'b0;
        hit_out_q <= 1'b0;
      end else if (v3_q) begin
        if (d2 < SW'(ri2_q)) hit_in_q  <= 1'b1;
        if (d2 < SW'(ro2_q)) hit_out_q <= 1'b1;
      end
      if (out_load_o) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  assign out_valid_o  = ov_q;
  assign point_x_o    = op_q[0];
  assign point_y_o    = op_q[1];
  assign point_z_o    = op_q[2];
  assign in_shell_o   = oin_q;
  assign keep_o       = okeep_q;
  assign last_point_o = olast_q;

endmodule
`default_nettype wire

@@ design/shell_grid_point_selector.sv @@
`default_nettype none
// the back end scans one atom a cycle and pops a new point only once the last result is loaded
// every transaction waits while the point queue is full; loads and clears also wait until the
// queue is empty and the back end is idle
// the atom table needs no clearing pass, only entries below the atom count are read
// reset (rst_ni low, asynchronous) zeroes the atom count, resets the box, walk and registers
module shell_grid_point_selector
  import sgps_pkg::*;
#(
  parameter int MAX_ATOMS  = MAX_ATOMS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [OP_W-1:0]              op_i,
  input  logic signed [COORD_BITS-1:0] atom_x_i,
  input  logic signed [COORD_BITS-1:0] atom_y_i,
  input  logic signed [COORD_BITS-1:0] atom_z_i,
  input  logic [RADIUS_W-1:0]          atom_radius_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [COORD_BITS-1:0] point_x_o,
  output logic signed [COORD_BITS-1:0] point_y_o,
  output logic signed [COORD_BITS-1:0] point_z_o,
  output logic                         in_shell_o,
  output logic                         keep_o,
  output logic                         last_point_o
);

  localparam int CW = $clog2(MAX_ATOMS + 1);
  localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int EW = 3 * COORD_BITS + RADIUS_W;
  localparam int JW = 3 * pos_width(COORD_BITS) + 1;

  // configuration registers, always writable
  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_MODE:          cfg_d.mode          = cfg_data_i[2:0];
        REG_OUTER_SHIFT:   cfg_d.outer_shift   = cfg_data_i[14:0];
        REG_INNER_SHIFT:   cfg_d.inner_shift   = $signed(cfg_data_i);
        REG_OUTER_CUTOFF:  cfg_d.outer_cutoff  = cfg_data_i[14:0];
        REG_INNER_CUTOFF:  cfg_d.inner_cutoff  = cfg_data_i[14:0];
        REG_FIXED_PADDING: cfg_d.fixed_padding = cfg_data_i[14:0];
        REG_SPACING:       cfg_d.spacing       = cfg_data_i[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{mode: '0, outer_shift: '0, inner_shift: '0, outer_cutoff: '0,
                 inner_cutoff: '0, fixed_padding: '0, spacing: SPACING_RESET};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_ready_o = 1'b1;

  // front end: table loads, bounding box, walk position
  flow_t          flow;
  logic           q_push, q_pop, q_full, q_empty, back_busy, out_load;
  logic [JW-1:0]  q_wdata, q_rdata;
  logic           mem_we;
  logic [AW-1:0]  mem_addr;
  logic [EW-1:0]  mem_data;
  logic [CW-1:0]  atom_count;

  assign flow.full      = q_full;
  assign flow.empty     = q_empty;
  assign flow.back_busy = back_busy;

  sgps_front #(
    .MAX_ATOMS  (MAX_ATOMS),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .flow_i        (flow),
    .in_valid_i    (in_valid_i),
    .op_i          (op_i),
    .atom_x_i      (atom_x_i),
    .atom_y_i      (atom_y_i),
    .atom_z_i      (atom_z_i),
    .atom_radius_i (atom_radius_i),
    .in_stall_o    (in_stall_o),
    .push_o        (q_push),
    .push_data_o   (q_wdata),
    .mem_we_o      (mem_we),
    .mem_addr_o    (mem_addr),
    .mem_data_o    (mem_data),
    .count_o       (atom_count)
  );

  // point queue between walk and shell test
  sgps_queue #(
    .DW (JW)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  // back end: atom table and per-point shell test, one atom per cycle
  sgps_back #(
    .MAX_ATOMS  (MAX_ATOMS),
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .mem_we_i     (mem_we),
    .mem_addr_i   (mem_addr),
    .mem_data_i   (mem_data),
    .count_i      (atom_count),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .pop_o        (q_pop),
    .busy_o       (back_busy),
    .out_load_o   (out_load),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .point_z_o    (point_z_o),
    .in_shell_o   (in_shell_o),
    .keep_o       (keep_o),
    .last_point_o (last_point_o)
  );

`ifndef ASSERT_OFF
  // queue never overflows
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full) else $error("point queue overflow");

  // table is written only while no point is pending or being scanned
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (!back_busy && q_empty)) else $error("table write during scan");

  // a new result never overwrites one still waiting
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !(out_valid_o && out_stall_i)) else $error("result overwritten");

  // keep always covers in_shell
  a_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (keep_o || !in_shell_o)) else $error("in-shell point not kept");
`endif

endmodule
`default_nettype wire

@@ tb/tb_shell_grid_point_selector.sv @@
`default_nettype none
module tb_shell_grid_point_selector;
  import sgps_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int TABLE_DEPTH = MAX_ATOMS_DEF;
  localparam logic [OP_W-1:0] OP_NONE = 2'd3;  // unused opcode, must be ignored
  localparam int TARGET_ITEMS = 1400;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 40;  // longer than one point scan
  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    bit shell;
    bit keep;
    bit last;
  } point_t;

  // directed table row; chk marks rows whose point is typed in by hand
  typedef struct {
    logic [OP_W-1:0] op;
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] z;
    logic [RADIUS_W-1:0] r;
    bit chk;
    point_t pt;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [OP_W-1:0] op_i = OP_NONE;
  logic signed [CB-1:0] atom_x_i = '0;
  logic signed [CB-1:0] atom_y_i = '0;
  logic signed [CB-1:0] atom_z_i = '0;
  logic [RADIUS_W-1:0] atom_radius_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CB-1:0] point_x_o;
  logic signed [CB-1:0] point_y_o;
  logic signed [CB-1:0] point_z_o;
  logic in_shell_o;
  logic keep_o;
  logic last_point_o;

  shell_grid_point_selector dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .op_i, .atom_x_i, .atom_y_i, .atom_z_i, .atom_radius_i,
    .out_valid_o, .out_stall_i, .point_x_o, .point_y_o, .point_z_o,
    .in_shell_o, .keep_o, .last_point_o
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------- shadow model of the selector ----------------
  longint atm_x[TABLE_DEPTH];
  longint atm_y[TABLE_DEPTH];
  longint atm_z[TABLE_DEPTH];
  longint atm_r[TABLE_DEPTH];
  int n_atoms;
  longint bmin[3];
  longint bmax[3];
  longint rad_pad;
  longint wpos[3];
  bit walking;
  bit walk_over;

  bit [2:0] r_mode;
  longint r_oshift, r_ishift, r_ocut, r_icut, r_fpad, r_spacing;

  point_t pending_points[$];  // points still owed by the block
  int errors = 0;
  int items_sent = 0;
  int tx_idle_pct = 17;
  int rx_idle_pct = 76;
  bit hold_req = 0;
  int hold_left = 0;
  bit typed_on = 0;
  point_t typed_pt;

  function automatic void clear_selector();
    n_atoms = 0;
    for (int a = 0; a < 3; a++) begin
      bmin[a] = (longint'(1) << (CB - 1)) - 1;
      bmax[a] = -(longint'(1) << (CB - 1));
      wpos[a] = 0;
    end
    rad_pad = 0;
    walking = 0;
    walk_over = 0;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_MODE:          r_mode = d[2:0];
      REG_OUTER_SHIFT:   r_oshift = longint'(d[14:0]);
      REG_INNER_SHIFT:   r_ishift = longint'($signed(d));
      REG_OUTER_CUTOFF:  r_ocut = longint'(d[14:0]);
      REG_INNER_CUTOFF:  r_icut = longint'(d[14:0]);
      REG_FIXED_PADDING: r_fpad = longint'(d[14:0]);
      REG_SPACING:       r_spacing = longint'(d[14:0]);
      default: ;
    endcase
  endfunction

  // applies one transaction to the model; returns 1 when the transaction yields a point
  function automatic bit next_point(logic [OP_W-1:0] op, logic signed [CB-1:0] x,
                                    logic signed [CB-1:0] y, logic signed [CB-1:0] z,
                                    logic [RADIUS_W-1:0] r, output point_t pt);
    longint pad, stp, d2, dx, dy, dz, ro, ri;
    longint lo[3];
    longint hi[3];
    longint p[3];
    bit hit, fin;
    pt = '{default: 0};
    if (op == OP_CLEAR) begin
      clear_selector();
      return 0;
    end
    if (op == OP_LOAD) begin
      if (n_atoms >= TABLE_DEPTH) return 0;
      atm_x[n_atoms] = x;
      atm_y[n_atoms] = y;
      atm_z[n_atoms] = z;
      atm_r[n_atoms] = longint'(r);
      p[0] = x; p[1] = y; p[2] = z;
      for (int a = 0; a < 3; a++) begin
        if (p[a] < bmin[a]) bmin[a] = p[a];
        if (p[a] > bmax[a]) bmax[a] = p[a];
      end
      if (atm_r[n_atoms] + r_oshift > rad_pad) rad_pad = atm_r[n_atoms] + r_oshift;
      n_atoms++;
      return 0;
    end
    if (op != OP_STEP || n_atoms == 0 || walk_over) return 0;
    pad = r_mode[0] ? rad_pad : r_fpad;
    stp = (r_spacing > 0) ? r_spacing : 1;
    for (int a = 0; a < 3; a++) begin
      lo[a] = bmin[a] - pad;
      hi[a] = bmax[a] + pad;
    end
    if (!walking) begin
      for (int a = 0; a < 3; a++) wpos[a] = lo[a];
      walking = 1;
    end
    for (int a = 0; a < 3; a++) begin
      if (wpos[a] >= hi[a]) begin
        walk_over = 1;  // empty box ends the walk silently
        return 0;
      end
      p[a] = wpos[a];
    end
    hit = 0;
    for (int i = 0; i < n_atoms; i++) begin
      dx = p[0] - atm_x[i];
      dy = p[1] - atm_y[i];
      dz = p[2] - atm_z[i];
      d2 = dx * dx + dy * dy + dz * dz;
      ro = r_mode[0] ? atm_r[i] + r_oshift : r_ocut;
      ri = r_mode[1] ? atm_r[i] + r_ishift : r_icut;
      if (d2 < ri * ri) begin
        hit = 0;
        break;
      end
      if (d2 < ro * ro) hit = 1;
    end
    // z fastest, then y, then x
    fin = 0;
    wpos[2] += stp;
    if (wpos[2] >= hi[2]) begin
      wpos[2] = lo[2];
      wpos[1] += stp;
      if (wpos[1] >= hi[1]) begin
        wpos[1] = lo[1];
        wpos[0] += stp;
        if (wpos[0] >= hi[0]) fin = 1;
      end
    end
    if (fin) walk_over = 1;
    pt.x = p[0][CB-1:0];
    pt.y = p[1][CB-1:0];
    pt.z = p[2][CB-1:0];
    pt.shell = hit;
    pt.keep = hit | r_mode[2];
    pt.last = fin;
    return 1;
  endfunction

  // ---------------- drivers ----------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // called at a falling edge; leaves valid high after the transaction
  task automatic send(logic [OP_W-1:0] op, logic [CB-1:0] x, logic [CB-1:0] y,
                      logic [CB-1:0] z, logic [RADIUS_W-1:0] r);
    point_t pt;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    op_i = op;
    atom_x_i = x;
    atom_y_i = y;
    atom_z_i = z;
    atom_radius_i = r;
    do @(posedge clk_i); while (in_stall_o);
    if (next_point(op, x, y, z, r, pt))
      pending_points.insert(pending_points.size(), typed_on ? typed_pt : pt);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_points.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // ---------------- receiver stall ----------------
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = 1500;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point transaction x=%0d y=%0d z=%0d", point_x_o, point_y_o,
               point_z_o);
        errors++;
      end else begin
        e = pending_points.pop_front();
        if (point_x_o !== e.x) begin
          $error("point_x expected %0d got %0d", e.x, point_x_o); errors++;
        end
        if (point_y_o !== e.y) begin
          $error("point_y expected %0d got %0d", e.y, point_y_o); errors++;
        end
        if (point_z_o !== e.z) begin
          $error("point_z expected %0d got %0d", e.z, point_z_o); errors++;
        end
        if (in_shell_o !== e.shell) begin
          $error("in_shell expected %0b got %0b", e.shell, in_shell_o); errors++;
        end
        if (keep_o !== e.keep) begin
          $error("keep expected %0b got %0b", e.keep, keep_o); errors++;
        end
        if (last_point_o !== e.last) begin
          $error("last_point expected %0b got %0b", e.last, last_point_o); errors++;
        end
      end
    end
  end

  // watchdog
  longint cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  localparam logic [CB-1:0] CMIN = {1'b1, {(CB - 1){1'b0}}};
  localparam logic [CB-1:0] CMAX = {1'b0, {(CB - 1){1'b1}}};

  row_t rows[$];

  function automatic row_t mk(logic [OP_W-1:0] op, logic [CB-1:0] x, logic [CB-1:0] y,
                              logic [CB-1:0] z, logic [RADIUS_W-1:0] r);
    row_t w;
    w = '{op: op, x: x, y: y, z: z, r: r, chk: 0, pt: '{default: 0}};
    return w;
  endfunction

  function automatic void add_row(row_t w);
    rows.insert(rows.size(), w);
  endfunction

  function automatic logic [CB-1:0] rnd_c();
    return CB'($urandom);
  endfunction

  function automatic logic [RADIUS_W-1:0] rnd_r();
    return RADIUS_W'($urandom);
  endfunction

  function automatic logic [CB-1:0] near(longint c);
    longint v;
    v = c + longint'($urandom_range(6000)) - 3000;
    return v[CB-1:0];
  endfunction

  // one well-formed walk: clear, load a cluster, then step with some noise
  task automatic run_walk(bit fill);
    longint cx, cy, cz;
    int k, s;
    logic [RADIUS_W-1:0] r;
    cx = longint'($urandom_range(800000)) - 400000;
    cy = longint'($urandom_range(800000)) - 400000;
    cz = longint'($urandom_range(800000)) - 400000;
    if ($urandom_range(9) == 0) cx = 520000;  // cluster near the top of the range
    if ($urandom_range(9) == 0) cz = -520000;
    send(OP_CLEAR, rnd_c(), rnd_c(), rnd_c(), rnd_r());
    k = fill ? TABLE_DEPTH + 3 : $urandom_range(6, 1);  // fill also tries loads when full
    for (int i = 0; i < k; i++) begin
      r = ($urandom_range(7) == 0) ? rnd_r() : RADIUS_W'($urandom_range(3000));
      if ($urandom_range(19) == 0)
        send(OP_LOAD, rnd_c(), rnd_c(), rnd_c(), r);
      else
        send(OP_LOAD, near(cx), near(cy), near(cz), r);
    end
    s = 0;
    while (s < (fill ? 4 : 30) && !walk_over) begin
      case ($urandom_range(19))
        0: send(OP_NONE, rnd_c(), rnd_c(), rnd_c(), rnd_r());
        1: send(OP_LOAD, near(cx), near(cy), near(cz), RADIUS_W'($urandom_range(3000)));
        default: begin
          send(OP_STEP, rnd_c(), rnd_c(), rnd_c(), rnd_r());
          s++;
        end
      endcase
    end
    // at times one more step; past the end it must yield nothing
    if ($urandom_range(3) == 0) send(OP_STEP, rnd_c(), rnd_c(), rnd_c(), rnd_r());
  endtask

  task automatic program_regs(int ph);
    logic [CFG_DATA_W-1:0] v[7];
    int spc[5] = '{1024, 4096, 8192, 16384, 32767};
    if (ph == 0) v = '{16'd7, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff};
    else if (ph == 1) v = '{16'd0, 16'd0, 16'h7fff, 16'd0, 16'd0, 16'd0, 16'd0};
    else begin
      v[0] = CFG_DATA_W'($urandom_range(7));
      v[1] = CFG_DATA_W'($urandom_range(3000));
      v[2] = CFG_DATA_W'($urandom_range(4000)) - 16'd2000;
      v[3] = CFG_DATA_W'($urandom_range(8000));
      v[4] = CFG_DATA_W'($urandom_range(3000));
      v[5] = CFG_DATA_W'($urandom_range(4000));
      v[6] = CFG_DATA_W'(spc[$urandom_range(4)]);
      if ($urandom_range(7) == 0) v[6] = CFG_DATA_W'($urandom);  // stray upper bit
    end
    write_reg(REG_MODE, v[0]);
    write_reg(REG_OUTER_SHIFT, v[1]);
    write_reg(REG_INNER_SHIFT, v[2]);
    write_reg(REG_OUTER_CUTOFF, v[3]);
    write_reg(REG_INNER_CUTOFF, v[4]);
    write_reg(REG_FIXED_PADDING, v[5]);
    write_reg(REG_SPACING, v[6]);
  endtask

  initial begin
    row_t w;
    int ph;
    ph = 0;
    r_mode = 0; r_oshift = 0; r_ishift = 0; r_ocut = 0; r_icut = 0; r_fpad = 0;
    r_spacing = longint'(SPACING_RESET);
    clear_selector();

    // directed rows, run with reset register values
    add_row(mk(OP_STEP, 0, 0, 0, 0));             // empty table, no point
    add_row(mk(OP_NONE, CMAX, CMIN, CMAX, '1));   // unused opcode
    add_row(mk(OP_LOAD, 0, 0, 0, 0));
    add_row(mk(OP_STEP, 0, 0, 0, 0));             // zero-size box ends the walk
    add_row(mk(OP_STEP, 0, 0, 0, 0));             // walk over, no point
    add_row(mk(OP_CLEAR, 0, 0, 0, 0));
    add_row(mk(OP_LOAD, CMIN, CMIN, CMIN, '1));
    add_row(mk(OP_LOAD, CMAX, CMAX, CMAX, 0));
    w = mk(OP_STEP, 0, 0, 0, 0);                  // first corner of the full box
    w.chk = 1;
    w.pt = '{x: CMIN, y: CMIN, z: CMIN, shell: 0, keep: 0, last: 0};
    add_row(w);
    add_row(mk(OP_STEP, 0, 0, 0, 0));
    add_row(mk(OP_STEP, 0, 0, 0, 0));
    add_row(mk(OP_LOAD, 100, -200, 300, 1500));   // load inside the box during the walk
    add_row(mk(OP_STEP, 0, 0, 0, 0));
    add_row(mk(OP_CLEAR, 0, 0, 0, 0));
    add_row(mk(OP_LOAD, 1000, 2000, -3000, 2048));
    add_row(mk(OP_LOAD, 3000, 2500, -1000, 1200));
    for (int i = 0; i < 6; i++) add_row(mk(OP_STEP, 0, 0, 0, 0));

    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      typed_on = rows[i].chk;
      typed_pt = rows[i].pt;
      send(rows[i].op, rows[i].x, rows[i].y, rows[i].z, rows[i].r);
      typed_on = 0;
    end

    // random part: phases separated by idle register updates
    while (items_sent < TARGET_ITEMS) begin
      drain();
      if (items_sent < TARGET_ITEMS / 3) begin
        tx_idle_pct = 17; rx_idle_pct = 76;
      end else if (items_sent < 2 * TARGET_ITEMS / 3) begin
        tx_idle_pct = 76; rx_idle_pct = 17;
      end else begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      program_regs(ph);
      if (ph == 2) hold_req = 1;  // long output hold while steps keep coming
      for (int wk = 0; wk < 4; wk++) begin
        run_walk(ph == 3 && wk == 0);
        if (wk == 1) begin
          // sender pauses until every owed point is out
          in_valid_i = 1'b0;
          while (pending_points.size() != 0) @(negedge clk_i);
        end
      end
      ph++;
    end

    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ shell_grid_point_selector.f @@
design/sgps_pkg.sv
design/sgps_queue.sv
design/sgps_front.sv
design/sgps_back.sv
design/shell_grid_point_selector.sv
tb/tb_shell_grid_point_selector.sv
